### hw/rtl/drt_pkg.sv
// Package: shared types and constants for the dedup reference-count table.
package drt_pkg;

    localparam int ENTRIES   = 1024;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = IDX_W + 1;
    localparam int BUCKET_W  = 16;
    localparam int REFS_W    = 32;
    localparam int QDEPTH    = 2;

    localparam logic [1:0] MODE_FIND   = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_REF    = 2'd2;
    localparam logic [1:0] MODE_UNREF  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMATCH = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [REFS_W-1:0] REFS_MAX = '1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] digest_w0;
        logic [63:0] digest_w1;
        logic [63:0] digest_w2;
        logic [63:0] digest_w3;
        logic [63:0] blk_num;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] found_block;
    } t_rsp;

    // request after classification by the front end
    typedef struct packed {
        t_req                req;
        logic                by_digest;
        logic [BUCKET_W-1:0] bucket;
    } t_cmd;

    function automatic logic [BUCKET_W-1:0] bucket_of(input t_req r);
        logic [31:0] h;
        h = r.digest_w0[31:0] ^ r.digest_w0[63:32] ^ r.digest_w1[31:0] ^ r.digest_w1[63:32]
          ^ r.digest_w2[31:0] ^ r.digest_w2[63:32] ^ r.digest_w3[31:0] ^ r.digest_w3[63:32];
        return h[BUCKET_W-1:0];
    endfunction

endpackage

### hw/rtl/dedup_refcount_table.sv
// Dedup table top: front end, command queue and scanning back end.
// One request at a time, set by the memory scan, which reads one slot per cycle.
// Busy stays high from acceptance until the result strobe; the receiver cannot stall.
// Synchronous active-low reset empties the table and clears the insertion stamp;
// a valid-bit clearing pass over every entry follows, and a request accepted then waits.
module dedup_refcount_table import drt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_rsp o_rsp
);
    logic q_valid, q_pop;
    t_cmd q_cmd;

    drt_front u_front (
        .i_clk, .i_rst_n, .i_start(start), .i_req, .o_busy(busy),
        .o_q_valid(q_valid), .o_q_cmd(q_cmd), .i_q_pop(q_pop)
    );

    drt_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .i_q_cmd(q_cmd),
        .o_q_pop(q_pop), .o_done, .o_rsp
    );

`ifndef SYNTHESIS
    a_done_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> o_done) else $error("result strobe missing after command retire");
    a_pop_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid) else $error("command retired from empty queue");
    a_busy_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("busy still high at result");
`endif
endmodule

### hw/rtl/drt_front.sv
// Front end: takes requests, computes bucket and lookup kind, feeds command queue.
module drt_front import drt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    output logic o_busy,
    output logic o_q_valid,
    output t_cmd o_q_cmd,
    input  logic i_q_pop
);
    localparam int PW = $clog2(QDEPTH);

    t_cmd            r_q [QDEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;
    logic            push;
    t_cmd            cmd;

    // one request at a time: busy until the back end answers
    logic r_pending;

    assign o_busy    = r_pending;
    assign push      = i_start && !r_pending;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_cmd   = r_q[r_rp];

    always_comb begin
        cmd.req       = i_req;
        cmd.by_digest = (i_req.mode == MODE_FIND) || (i_req.mode == MODE_INSERT);
        cmd.bucket    = bucket_of(i_req);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_rp      <= '0;
            r_cnt     <= '0;
            r_pending <= 1'b0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_q_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(push) - (PW+1)'(i_q_pop);
            if (push) begin
                r_pending <= 1'b1;
            end else if (i_q_pop) begin
                r_pending <= 1'b0;
            end
        end
    end
endmodule

### hw/rtl/drt_back.sv
// Back end: scans the entry memories one slot a cycle and applies the update.
module drt_back import drt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_cmd i_q_cmd,
    output logic o_q_pop,
    output logic o_done,
    output t_rsp o_rsp
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_CLR  = 2'd3;

    logic [255:0]          m_dig   [ENTRIES];
    logic [63:0]           m_blk   [ENTRIES];
    logic [REFS_W-1:0]     m_refs  [ENTRIES];
    logic [BUCKET_W-1:0]   m_bkt   [ENTRIES];
    logic [63:0]           m_stamp [ENTRIES];
    logic                  m_valid [ENTRIES];

    logic [1:0]            r_state;
    t_cmd                  r_cmd;
    logic [CNT_W-1:0]      r_addr;      // address issued
    logic                  r_rd_v;      // read data valid this cycle
    logic [IDX_W-1:0]      r_rd_idx;
    logic [255:0]          r_rd_dig;
    logic [63:0]           r_rd_blk;
    logic [REFS_W-1:0]     r_rd_refs;
    logic [BUCKET_W-1:0]   r_rd_bkt;
    logic [63:0]           r_rd_stamp;
    logic                  r_rd_valid;

    logic                  r_hit;
    logic [IDX_W-1:0]      r_hit_idx;
    logic [63:0]           r_hit_blk;
    logic [REFS_W-1:0]     r_hit_refs;
    logic [BUCKET_W-1:0]   r_hit_bkt;
    logic [63:0]           r_hit_stamp;
    logic                  r_free_v;
    logic [IDX_W-1:0]      r_free_idx;
    logic [63:0]           r_icnt;

    logic                  match, better;
    logic [255:0]          q_dig;
    logic [REFS_W-1:0]     new_refs;

    assign q_dig = {r_cmd.req.digest_w3, r_cmd.req.digest_w2,
                    r_cmd.req.digest_w1, r_cmd.req.digest_w0};
    assign o_q_pop = (r_state == S_UPD);

    always_comb begin
        match  = 1'b0;
        better = 1'b0;
        if (r_rd_v && r_rd_valid) begin
            if (r_cmd.by_digest) begin
                match  = (r_rd_dig == q_dig);
                better = match && !r_hit;
            end else begin
                match  = (r_rd_blk == r_cmd.req.blk_num);
                better = match && (!r_hit || (r_rd_bkt < r_hit_bkt) ||
                         ((r_rd_bkt == r_hit_bkt) && (r_rd_stamp > r_hit_stamp)));
            end
        end
    end

    always_comb begin
        new_refs = r_hit_refs;
        if (r_cmd.req.mode == MODE_UNREF) begin
            if (r_hit_refs != '0) begin
                new_refs = r_hit_refs - 1'b1;
            end
        end else if (r_hit_refs != REFS_MAX) begin
            new_refs = r_hit_refs + 1'b1;
        end
    end

    // memories: one read port, one write port
    always_ff @(posedge i_clk) begin
        r_rd_dig   <= m_dig[r_addr[IDX_W-1:0]];
        r_rd_blk   <= m_blk[r_addr[IDX_W-1:0]];
        r_rd_refs  <= m_refs[r_addr[IDX_W-1:0]];
        r_rd_bkt   <= m_bkt[r_addr[IDX_W-1:0]];
        r_rd_stamp <= m_stamp[r_addr[IDX_W-1:0]];
        r_rd_valid <= m_valid[r_addr[IDX_W-1:0]];
        if (r_state == S_CLR) begin
            m_valid[r_addr[IDX_W-1:0]] <= 1'b0;
        end else if (r_state == S_UPD) begin
            if (r_hit && r_cmd.req.mode != MODE_FIND) begin
                m_refs[r_hit_idx] <= new_refs;
                if (r_cmd.req.mode == MODE_UNREF && new_refs == '0) begin
                    m_valid[r_hit_idx] <= 1'b0;
                end
            end else if (!r_hit && r_cmd.req.mode == MODE_INSERT && r_free_v) begin
                m_dig[r_free_idx]   <= q_dig;
                m_blk[r_free_idx]   <= r_cmd.req.blk_num;
                m_refs[r_free_idx]  <= REFS_W'(1);
                m_bkt[r_free_idx]   <= r_cmd.bucket;
                m_stamp[r_free_idx] <= r_icnt;
                m_valid[r_free_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr[IDX_W-1:0];
        if (r_state == S_IDLE) begin
            r_cmd <= i_q_cmd;
        end
        if (better) begin
            r_hit_idx   <= r_rd_idx;
            r_hit_blk   <= r_rd_blk;
            r_hit_refs  <= r_rd_refs;
            r_hit_bkt   <= r_rd_bkt;
            r_hit_stamp <= r_rd_stamp;
        end
        if (r_rd_v && !r_rd_valid && !r_free_v) begin
            r_free_idx <= r_rd_idx;
        end
        o_rsp.status      <= ST_NOMATCH;
        o_rsp.found_block <= '0;
        if (r_state == S_UPD) begin
            if (r_hit) begin
                o_rsp.status <= ST_OK;
                if (r_cmd.req.mode == MODE_FIND) begin
                    o_rsp.found_block <= r_hit_blk;
                end
            end else if (r_cmd.req.mode == MODE_INSERT) begin
                o_rsp.status <= r_free_v ? ST_OK : ST_FULL;
            end
        end
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_icnt   <= '0;
            r_addr   <= '0;
            r_rd_v   <= 1'b0;
            r_hit    <= 1'b0;
            r_free_v <= 1'b0;
            o_done   <= 1'b0;
        end else begin
            o_done <= (r_state == S_UPD);
            if (better) begin
                r_hit <= 1'b1;
            end
            if (r_rd_v && !r_rd_valid) begin
                r_free_v <= 1'b1;
            end
            unique case (r_state)
                S_CLR: begin
                    // clear one valid bit per cycle after reset
                    if (r_addr == CNT_W'(ENTRIES - 1)) begin
                        r_addr  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    r_addr   <= '0;
                    r_rd_v   <= 1'b0;
                    r_hit    <= 1'b0;
                    r_free_v <= 1'b0;
                    if (i_q_valid) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_addr < CNT_W'(ENTRIES)) begin
                        r_addr <= r_addr + 1'b1;
                        r_rd_v <= 1'b1;
                    end else begin
                        r_rd_v <= 1'b0;
                        if (!r_rd_v) begin
                            r_state <= S_UPD;
                        end
                    end
                end
                S_UPD: begin
                    r_state <= S_IDLE;
                    if (!r_hit && r_cmd.req.mode == MODE_INSERT && r_free_v) begin
                        r_icnt <= r_icnt + 1'b1;
                    end
                end
            endcase
        end
    end
endmodule
